FILE: rtl/core/wrbd_pkg.sv
package wrbd_pkg;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int COUNT_W    = 32;
  localparam int COOLDOWN_W = 16;
  localparam int WARM_W     = 8;
  localparam int TAKEN_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Default window depth
  localparam int WINDOW_DEF = 32;

  // Saturation point of the sample counter
  localparam logic [TAKEN_W-1:0] TAKEN_MAX = 9'd511;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARM_UP_COUNT   = 2'd2;

  // Configuration reset values (threshold is 0.35 in Q4.11)
  localparam logic [SAMPLE_W-1:0]   THRESHOLD_RST = 16'd717;
  localparam logic [COOLDOWN_W-1:0] COOLDOWN_RST  = 16'd50;
  localparam logic [WARM_W-1:0]     WARM_UP_RST   = 8'd30;

endpackage

FILE: rtl/core/wrbd_ram.sv
module wrbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/wrbd_scan.sv
module wrbd_scan #(
  parameter int WINDOW = wrbd_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [$clog2(WINDOW+1)-1:0]       count,
  output logic                              rd_en,
  output logic [$clog2(WINDOW)-1:0]         rd_addr,
  input  logic [wrbd_pkg::SAMPLE_W-1:0]     rd_data,
  output logic                              done,
  output logic [$clog2(WINDOW)-1:0]         hi_at,
  output logic [$clog2(WINDOW)-1:0]         lo_at,
  output logic [wrbd_pkg::SAMPLE_W-1:0]     range_val
);

  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW+1);

  logic                                busy_r;
  logic [AW-1:0]                       addr_r;
  logic [CW-1:0]                       cnt_r;
  logic                                vld_r;
  logic [AW-1:0]                       idx_r;
  logic                                done_r;
  logic signed [wrbd_pkg::SAMPLE_W-1:0] hi_r;
  logic signed [wrbd_pkg::SAMPLE_W-1:0] lo_r;
  logic [AW-1:0]                       hi_at_r;
  logic [AW-1:0]                       lo_at_r;
  logic signed [wrbd_pkg::SAMPLE_W-1:0] data_s;
  logic                                issue;

  assign issue     = busy_r && (cnt_r != '0);
  assign rd_en     = issue;
  assign rd_addr   = addr_r;
  assign data_s    = $signed(rd_data);
  assign done      = done_r;
  assign hi_at     = hi_at_r;
  assign lo_at     = lo_at_r;
  assign range_val = hi_r - lo_r;

  // Walk the slots from zero, one read per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
      done_r <= 1'b0;
      addr_r <= '0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      vld_r  <= issue;
      if (start) begin
        busy_r <= 1'b1;
        addr_r <= '0;
        cnt_r  <= count;
      end else if (issue) begin
        addr_r <= addr_r + AW'(1);
        cnt_r  <= cnt_r - CW'(1);
      end
      // Last read data absorbed: finish
      if (vld_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Track first maximum and first minimum
  always_ff @(posedge clk) begin
    idx_r <= addr_r;
    if (vld_r) begin
      if (idx_r == '0) begin
        hi_r    <= data_s;
        lo_r    <= data_s;
        hi_at_r <= '0;
        lo_at_r <= '0;
      end else begin
        if (data_s > hi_r) begin
          hi_r    <= data_s;
          hi_at_r <= idx_r;
        end
        if (data_s < lo_r) begin
          lo_r    <= data_s;
          lo_at_r <= idx_r;
        end
      end
    end
  end

endmodule

FILE: rtl/core/window_range_bump_detector.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_sample (signed Q4.11)
// out_      output     out_valid / out_stall  bump_now, bump_total, bump_seen,
//                                             detection_ran, window_range
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item that runs the window scan goes from accept through the scan of fill_count
// slots (at most WINDOW) and the result hand-off to the next accept; the scan reads
// one sample memory slot per cycle. Any other item skips the scan.
// Reset is synchronous, active low, and needs no clearing pass.
// One item is in work at a time; a new item is taken while the previous result
// waits in the output register under out_stall.
module window_range_bump_detector #(
  parameter int WINDOW = wrbd_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [wrbd_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_bump_now,
  output logic [wrbd_pkg::COUNT_W-1:0]        out_bump_total,
  output logic                                out_bump_seen,
  output logic                                out_detection_ran,
  output logic [wrbd_pkg::SAMPLE_W-1:0]       out_window_range,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wrbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wrbd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW+1);
  localparam int SW = wrbd_pkg::SAMPLE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                         state_r, state_nxt;
  logic [SW-1:0]                      threshold_r;
  logic [wrbd_pkg::COOLDOWN_W-1:0]    cool_len_r;
  logic [wrbd_pkg::WARM_W-1:0]        warm_up_r;
  logic [CW-1:0]                      fill_r, fill_nxt;
  logic [AW-1:0]                      wslot_r, wslot_nxt;
  logic [wrbd_pkg::TAKEN_W-1:0]       taken_r, taken_nxt;
  logic [SW-1:0]                      last_range_r, last_range_nxt;
  logic [AW-1:0]                      max_slot_r, max_slot_nxt;
  logic [AW-1:0]                      min_slot_r, min_slot_nxt;
  logic [wrbd_pkg::COUNT_W-1:0]       bump_count_r, bump_count_nxt;
  logic                               bump_flag_r, bump_flag_nxt;
  logic [wrbd_pkg::COOLDOWN_W-1:0]    cool_left_r, cool_left_nxt;
  logic                               res_now_r, res_now_nxt;
  logic                               res_ran_r, res_ran_nxt;
  logic [SW-1:0]                      res_range_r, res_range_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_load;

  logic                               accept;
  logic                               detect;
  logic                               scan_start;
  logic                               rd_en;
  logic [AW-1:0]                      rd_addr;
  logic [SW-1:0]                      rd_data;
  logic                               scan_done;
  logic [AW-1:0]                      scan_hi_at;
  logic [AW-1:0]                      scan_lo_at;
  logic [SW-1:0]                      scan_range;
  logic                               differs;

  assign accept    = (state_r == ST_IDLE) && in_valid;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  // Sample window storage
  wrbd_ram #(
    .WIDTH(SW),
    .DEPTH(WINDOW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (accept),
    .wr_addr(wslot_r),
    .wr_data(in_sample),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Max/min scan over the filled slots
  wrbd_scan #(
    .WINDOW(WINDOW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .count    (fill_nxt),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .done     (scan_done),
    .hi_at    (scan_hi_at),
    .lo_at    (scan_lo_at),
    .range_val(scan_range)
  );

  assign differs = (scan_range != last_range_r) && (scan_hi_at != max_slot_r) &&
                   (scan_lo_at != min_slot_r);

  // Window bookkeeping for the incoming sample
  assign fill_nxt  = (fill_r != CW'(WINDOW)) ? fill_r + CW'(1) : fill_r;
  assign wslot_nxt = (wslot_r == AW'(WINDOW-1)) ? '0 : wslot_r + AW'(1);
  assign taken_nxt = (taken_r != wrbd_pkg::TAKEN_MAX) ? taken_r + 9'd1 : taken_r;
  assign detect    = taken_nxt > {1'b0, warm_up_r};
  assign scan_start = accept && detect && (cool_left_r == '0);

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Sequence one transaction: accept, optional scan, hand off result
  always_comb begin
    state_nxt      = state_r;
    last_range_nxt = last_range_r;
    max_slot_nxt   = max_slot_r;
    min_slot_nxt   = min_slot_r;
    bump_count_nxt = bump_count_r;
    bump_flag_nxt  = bump_flag_r;
    cool_left_nxt  = cool_left_r;
    res_now_nxt    = res_now_r;
    res_ran_nxt    = res_ran_r;
    res_range_nxt  = res_range_r;
    out_valid_nxt  = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_now_nxt   = 1'b0;
          res_ran_nxt   = 1'b0;
          res_range_nxt = '0;
          if (scan_start) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
            if (detect) begin
              cool_left_nxt = cool_left_r - wrbd_pkg::COOLDOWN_W'(1);
            end
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          res_ran_nxt    = 1'b1;
          res_range_nxt  = scan_range;
          last_range_nxt = scan_range;
          if (differs) begin
            max_slot_nxt = scan_hi_at;
            min_slot_nxt = scan_lo_at;
            if (scan_range > threshold_r) begin
              if (bump_count_r != '1) begin
                bump_count_nxt = bump_count_r + 32'd1;
              end
              bump_flag_nxt = 1'b1;
              cool_left_nxt = cool_len_r;
              res_now_nxt   = 1'b1;
            end
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      threshold_r  <= wrbd_pkg::THRESHOLD_RST;
      cool_len_r   <= wrbd_pkg::COOLDOWN_RST;
      warm_up_r    <= wrbd_pkg::WARM_UP_RST;
      fill_r       <= '0;
      wslot_r      <= '0;
      taken_r      <= '0;
      last_range_r <= '0;
      max_slot_r   <= '0;
      min_slot_r   <= '0;
      bump_count_r <= '0;
      bump_flag_r  <= 1'b0;
      cool_left_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_range_r <= last_range_nxt;
      max_slot_r   <= max_slot_nxt;
      min_slot_r   <= min_slot_nxt;
      bump_count_r <= bump_count_nxt;
      bump_flag_r  <= bump_flag_nxt;
      cool_left_r  <= cool_left_nxt;
      out_valid_r  <= out_valid_nxt;
      if (accept) begin
        fill_r  <= fill_nxt;
        wslot_r <= wslot_nxt;
        taken_r <= taken_nxt;
      end
      // Configuration writes; unknown index is dropped
      if (cfg_valid) begin
        unique case (cfg_index)
          wrbd_pkg::REG_RANGE_THRESHOLD: threshold_r <= cfg_data;
          wrbd_pkg::REG_COOLDOWN_LENGTH: cool_len_r  <= cfg_data;
          wrbd_pkg::REG_WARM_UP_COUNT:   warm_up_r   <= cfg_data[wrbd_pkg::WARM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result and output payload
  always_ff @(posedge clk) begin
    res_now_r   <= res_now_nxt;
    res_ran_r   <= res_ran_nxt;
    res_range_r <= res_range_nxt;
    if (out_load) begin
      out_bump_now      <= res_now_r;
      out_bump_total    <= bump_count_r;
      out_bump_seen     <= bump_flag_r;
      out_detection_ran <= res_ran_r;
      out_window_range  <= res_range_r;
    end
  end

endmodule

FILE: rtl/core/wrbd_chk.sv
module wrbd_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                out_bump_now,
  input logic [wrbd_pkg::COUNT_W-1:0]        out_bump_total,
  input logic                                out_bump_seen,
  input logic                                out_detection_ran,
  input logic [wrbd_pkg::SAMPLE_W-1:0]       out_window_range
);

  // Block holds off the next transaction right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // A bump implies the scan ran and the sticky flag is set
  a_bump_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bump_now |-> out_bump_seen && out_detection_ran)
    else $error("bump without scan or flag");

  // No scan, no range
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_detection_ran |-> out_window_range == '0)
    else $error("range reported without scan");

  // Bump total never drops between consecutive results
  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(rst_n) && $past(out_valid) |->
      out_bump_total >= $past(out_bump_total))
    else $error("bump total decreased");

endmodule

bind window_range_bump_detector wrbd_chk u_wrbd_chk (.*);
